// ===== src/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants
// Payload structs, controller command/status bundles and datapath widths.
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int MAX_LOCAL  = 4096;
    localparam int MAX_REMOTE = 64;
    localparam int NP_W       = 13;
    localparam int ME_W       = 12;
    localparam int RNP_W      = 7;
    localparam int TOT_W      = 32;
    localparam int POS_W      = 48;
    localparam int PER_W      = 33;
    localparam int DVD_W      = 40;
    localparam int DVS_W      = 33;
    localparam int DCNT_W     = $clog2(DVD_W + 1);
    localparam int RANK_W     = 22;
    localparam int PEER_W     = 7;

    typedef struct packed {
        logic [12:0] local_count;
        logic [11:0] local_index;
        logic [6:0]  remote_count;
        logic [15:0] remote_base;
        logic [15:0] remote_stride;
        logic [31:0] have_total;
        logic [31:0] goal_total;
        logic [31:0] remote_have_total;
        logic [31:0] remote_goal_total;
    } t_in;

    typedef struct packed {
        logic        has_transfer;
        logic [21:0] peer_rank;
        logic        is_send;
        logic [31:0] item_count;
        logic        mismatch;
        logic        last;
    } t_out;

    typedef enum logic [2:0] {
        DS_HAVE  = 3'd0,
        DS_GOAL  = 3'd1,
        DS_RGOAL = 3'd2,
        DS_RHAVE = 3'd3,
        DS_PEER  = 3'd4
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     div_store;
        logic     blk_h;
        logic     blk_g;
        logic     prep;
        logic     prep2;
        logic     span;
        logic     seg_adv;
        logic     edge_calc;
        logic     cnt_calc;
        logic     push;
        logic     fin;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic rnp_zero;
        logic in_loop;
        logic seg_last;
        logic out_free;
        logic pend_valid;
    } t_sts;

endpackage

// ===== src/brs_div.sv =====
// ----------------------------------------------------------------------------
// brs_div: restoring divider
// One quotient bit per cycle; busy from a start pulse until every quotient bit is done.
// ----------------------------------------------------------------------------
module brs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [brs_pkg::DVD_W-1:0]  i_dividend,
    input  logic [brs_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [brs_pkg::DVD_W-1:0]  o_quot,
    output logic [brs_pkg::DVS_W-1:0]  o_rem
);

    logic [brs_pkg::DCNT_W-1:0] r_cnt;
    logic [brs_pkg::DVD_W-1:0]  r_quot;
    logic [brs_pkg::DVS_W-1:0]  r_rem;
    logic [brs_pkg::DVS_W-1:0]  r_dvs;
    logic [brs_pkg::DVS_W:0]    s_trial;
    logic                       s_ge;

    assign s_trial = {r_rem, r_quot[brs_pkg::DVD_W-1]};
    assign s_ge    = (s_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= brs_pkg::DCNT_W'(brs_pkg::DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[brs_pkg::DVD_W-2:0], s_ge};
            r_rem  <= s_ge ? brs_pkg::DVS_W'(s_trial - {1'b0, r_dvs})
                           : s_trial[brs_pkg::DVS_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== src/brs_dp.sv =====
// ----------------------------------------------------------------------------
// brs_dp: scheduler datapath
// Block splits, segment profile, per-peer transfer math and output register.
// ----------------------------------------------------------------------------
module brs_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  brs_pkg::t_in    i_data,
    input  brs_pkg::t_cmd   i_cmd,
    output brs_pkg::t_sts   o_sts,
    output logic            o_valid,
    input  logic            i_ready,
    output brs_pkg::t_out   o_data
);

    localparam int PW = brs_pkg::POS_W;

    // request
    logic [brs_pkg::NP_W-1:0]  r_np;
    logic [brs_pkg::ME_W-1:0]  r_me;
    logic [brs_pkg::RNP_W-1:0] r_rnp;
    logic [15:0]               r_base;
    logic [15:0]               r_stride;
    logic [31:0]               r_have;
    logic [31:0]               r_goal;
    logic [31:0]               r_rhave;
    logic [31:0]               r_rgoal;
    logic                      r_send;

    // division results
    brs_pkg::t_div_sel         r_dsel;
    logic [31:0]               r_qh;
    logic [31:0]               r_qg;
    logic [31:0]               r_q1;
    logic [31:0]               r_q2;
    logic [brs_pkg::NP_W-1:0]  r_rh;
    logic [brs_pkg::NP_W-1:0]  r_rg;
    logic [brs_pkg::RNP_W-1:0] r_r1;
    logic [brs_pkg::RNP_W-1:0] r_r2;

    // positions
    logic [PW-1:0] r_h0, r_h1, r_g0, r_g1, r_t0, r_t1, r_nloc, r_noff, r_span;
    logic [PW-1:0] r_prod, r_n;
    logic [brs_pkg::PER_W-1:0]  r_per0, r_per1, r_per2;
    logic [brs_pkg::RNP_W-1:0]  r_cut1, r_cut2;
    logic [1:0]                 r_seg;
    logic [brs_pkg::PEER_W-1:0] r_peer;
    logic [brs_pkg::RANK_W-1:0] r_rank;

    // pending transfer and output register
    logic                       r_pv;
    logic [brs_pkg::RANK_W-1:0] r_prank;
    logic [31:0]                r_pcnt;
    logic                       r_ov;
    brs_pkg::t_out              r_od;

    logic                       s_busy;
    logic [brs_pkg::DVD_W-1:0]  s_dvd, s_quot;
    logic [brs_pkg::DVS_W-1:0]  s_dvs, s_rem;
    logic [brs_pkg::NP_W-1:0]   s_np;
    logic [brs_pkg::RNP_W-1:0]  s_rnp;
    logic [brs_pkg::PER_W-1:0]  s_per;
    logic [brs_pkg::RNP_W-1:0]  s_cut_lo, s_cut_hi;
    logic [brs_pkg::NP_W-1:0]   s_me13, s_minh, s_ming;
    logic [brs_pkg::PER_W-1:0]  s_hsz, s_gsz;
    logic [43:0]                s_mh, s_mg;
    logic [33:0]                s_q1, s_q2, s_d0, s_d1;
    logic [PW-1:0]              s_edge, s_left, s_n, s_hi;
    logic                       s_mis, s_out_free;

    // clamp group sizes
    always_comb begin
        if (i_data.local_count == '0) begin
            s_np = brs_pkg::NP_W'(1);
        end else if (i_data.local_count > brs_pkg::NP_W'(brs_pkg::MAX_LOCAL)) begin
            s_np = brs_pkg::NP_W'(brs_pkg::MAX_LOCAL);
        end else begin
            s_np = i_data.local_count;
        end
        if (i_data.remote_count > brs_pkg::RNP_W'(brs_pkg::MAX_REMOTE)) begin
            s_rnp = brs_pkg::RNP_W'(brs_pkg::MAX_REMOTE);
        end else begin
            s_rnp = i_data.remote_count;
        end
    end

    // current segment
    always_comb begin
        case (r_seg)
            2'd0: begin
                s_per = r_per0; s_cut_lo = '0;     s_cut_hi = r_cut1;
            end
            2'd1: begin
                s_per = r_per1; s_cut_lo = r_cut1; s_cut_hi = r_cut2;
            end
            default: begin
                s_per = r_per2; s_cut_lo = r_cut2; s_cut_hi = r_rnp;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.div_sel)
            brs_pkg::DS_HAVE: begin
                s_dvd = brs_pkg::DVD_W'(r_have);  s_dvs = brs_pkg::DVS_W'(r_np);
            end
            brs_pkg::DS_GOAL: begin
                s_dvd = brs_pkg::DVD_W'(r_goal);  s_dvs = brs_pkg::DVS_W'(r_np);
            end
            brs_pkg::DS_RGOAL: begin
                s_dvd = brs_pkg::DVD_W'(r_rgoal); s_dvs = brs_pkg::DVS_W'(r_rnp);
            end
            brs_pkg::DS_RHAVE: begin
                s_dvd = brs_pkg::DVD_W'(r_rhave); s_dvs = brs_pkg::DVS_W'(r_rnp);
            end
            default: begin
                s_dvd = brs_pkg::DVD_W'(r_t0 - r_noff); s_dvs = s_per;
            end
        endcase
    end

    brs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (s_dvd),
        .i_divisor  (s_dvs),
        .o_busy     (s_busy),
        .o_quot     (s_quot),
        .o_rem      (s_rem)
    );

    // block sizes: quotient plus one for indices below the remainder
    assign s_me13 = brs_pkg::NP_W'(r_me);
    assign s_minh = (s_me13 < r_rh) ? s_me13 : r_rh;
    assign s_ming = (s_me13 < r_rg) ? s_me13 : r_rg;
    assign s_hsz  = brs_pkg::PER_W'(r_qh) + brs_pkg::PER_W'(s_me13 < r_rh);
    assign s_gsz  = brs_pkg::PER_W'(r_qg) + brs_pkg::PER_W'(s_me13 < r_rg);
    assign s_mh   = 44'(r_qh) * 44'(r_me);
    assign s_mg   = 44'(r_qg) * 44'(r_me);

    // remote profile
    assign s_q1 = 34'(r_q1);
    assign s_q2 = 34'(r_q2);
    assign s_d0 = (s_q1 >= s_q2) ? s_q1 - s_q2 : s_q2 - s_q1;
    always_comb begin
        if (r_r1 < r_r2) begin
            s_d1 = (s_q1 >= s_q2 + 34'd1) ? s_q1 - s_q2 - 34'd1 : s_q2 + 34'd1 - s_q1;
        end else begin
            s_d1 = (s_q1 + 34'd1 >= s_q2) ? s_q1 + 34'd1 - s_q2 : s_q2 - s_q1 - 34'd1;
        end
    end

    assign s_hi   = r_noff + r_span;
    assign s_edge = r_prod + r_noff - r_t0;
    assign s_left = r_t1 - r_t0;
    assign s_n    = (s_left < s_edge) ? s_left : s_edge;
    assign s_mis  = (r_nloc != PW'(s_gsz));
    assign s_out_free = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_np     <= s_np;
            r_me     <= i_data.local_index;
            r_rnp    <= s_rnp;
            r_base   <= i_data.remote_base;
            r_stride <= i_data.remote_stride;
            r_have   <= i_data.have_total;
            r_goal   <= i_data.goal_total;
            r_rhave  <= i_data.remote_have_total;
            r_rgoal  <= i_data.remote_goal_total;
            r_send   <= (i_data.have_total > i_data.goal_total);
        end
        if (i_cmd.div_start) begin
            r_dsel <= i_cmd.div_sel;
        end
        if (i_cmd.div_store) begin
            case (r_dsel)
                brs_pkg::DS_HAVE: begin
                    r_qh <= s_quot[31:0]; r_rh <= s_rem[brs_pkg::NP_W-1:0];
                end
                brs_pkg::DS_GOAL: begin
                    r_qg <= s_quot[31:0]; r_rg <= s_rem[brs_pkg::NP_W-1:0];
                end
                brs_pkg::DS_RGOAL: begin
                    r_q1 <= s_quot[31:0]; r_r1 <= s_rem[brs_pkg::RNP_W-1:0];
                end
                brs_pkg::DS_RHAVE: begin
                    r_q2 <= s_quot[31:0]; r_r2 <= s_rem[brs_pkg::RNP_W-1:0];
                end
                default: begin
                    r_peer <= s_cut_lo[brs_pkg::PEER_W-1:0]
                            + s_quot[brs_pkg::PEER_W-1:0];
                end
            endcase
        end
        if (i_cmd.blk_h) begin
            r_h0 <= PW'(s_mh) + PW'(s_minh);
        end
        if (i_cmd.blk_g) begin
            r_g0 <= PW'(s_mg) + PW'(s_ming);
        end
        if (i_cmd.prep) begin
            r_h1   <= r_h0 + PW'(s_hsz);
            r_g1   <= r_g0 + PW'(s_gsz);
            r_t0   <= (r_h0 >= r_g0) ? r_h0 - r_g0 : r_g0 - r_h0;
            r_nloc <= PW'(s_hsz);
            r_noff <= '0;
            r_seg  <= '0;
            r_per0 <= s_d0[brs_pkg::PER_W-1:0];
            r_per1 <= s_d1[brs_pkg::PER_W-1:0];
            r_per2 <= s_d0[brs_pkg::PER_W-1:0];
            r_cut1 <= (r_r1 < r_r2) ? r_r1 : r_r2;
            r_cut2 <= (r_r1 < r_r2) ? r_r2 : r_r1;
        end
        if (i_cmd.prep2) begin
            r_t1 <= (r_h1 >= r_g1) ? r_h1 - r_g1 : r_g1 - r_h1;
        end
        if (i_cmd.span) begin
            r_span <= PW'(40'(s_cut_hi - s_cut_lo) * 40'(s_per));
        end
        if (i_cmd.seg_adv) begin
            r_noff <= s_hi;
            r_seg  <= r_seg + 2'd1;
        end
        if (i_cmd.edge_calc) begin
            r_prod <= PW'(40'(s_per)
                    * 40'(brs_pkg::RNP_W'(r_peer) + 7'd1 - s_cut_lo));
        end
        if (i_cmd.cnt_calc) begin
            r_n    <= s_n;
            r_rank <= brs_pkg::RANK_W'(r_base)
                    + brs_pkg::RANK_W'(r_peer[5:0]) * brs_pkg::RANK_W'(r_stride);
        end
        if (i_cmd.push) begin
            r_prank <= r_rank;
            r_pcnt  <= r_n[31:0];
            r_t0    <= r_t0 + r_n;
            r_nloc  <= r_send ? r_nloc - r_n : r_nloc + r_n;
            r_peer  <= r_peer + 1'b1;
        end
    end

    // pending valid and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pv <= 1'b0;
            end else if (i_cmd.push) begin
                r_pv <= 1'b1;
            end
            if ((i_cmd.push && r_pv) || i_cmd.fin) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_pv) begin
            r_od <= '{has_transfer: 1'b1, peer_rank: r_prank, is_send: r_send,
                      item_count: r_pcnt, mismatch: 1'b0, last: 1'b0};
        end else if (i_cmd.fin) begin
            if (r_rnp == '0) begin
                r_od <= '{has_transfer: 1'b0, peer_rank: '0, is_send: 1'b0,
                          item_count: '0, mismatch: 1'b0, last: 1'b1};
            end else if (r_pv) begin
                r_od <= '{has_transfer: 1'b1, peer_rank: r_prank, is_send: r_send,
                          item_count: r_pcnt, mismatch: s_mis, last: 1'b1};
            end else begin
                r_od <= '{has_transfer: 1'b0, peer_rank: '0, is_send: 1'b0,
                          item_count: '0, mismatch: s_mis, last: 1'b1};
            end
        end
    end

    assign o_sts.div_busy   = s_busy;
    assign o_sts.rnp_zero   = (r_rnp == '0);
    assign o_sts.in_loop    = (s_per != '0) && (r_t0 < r_t1) && (r_t0 < s_hi);
    assign o_sts.seg_last   = (r_seg == 2'd2);
    assign o_sts.out_free   = s_out_free;
    assign o_sts.pend_valid = r_pv;
    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

// ===== src/brs_ctl.sv =====
// ----------------------------------------------------------------------------
// brs_ctl: scheduler controller
// Sequences divisions, setup, segment walk and result beats.
// ----------------------------------------------------------------------------
module brs_ctl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  brs_pkg::t_sts   i_sts,
    output brs_pkg::t_cmd   o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_START = 17'h00002,
        S_DIVH  = 17'h00004,
        S_DIVG  = 17'h00008,
        S_DIVRG = 17'h00010,
        S_DIVRH = 17'h00020,
        S_BLKH  = 17'h00040,
        S_BLKG  = 17'h00080,
        S_PREP  = 17'h00100,
        S_PREP2 = 17'h00200,
        S_SPAN  = 17'h00400,
        S_SEG   = 17'h00800,
        S_DIVP  = 17'h01000,
        S_EDGE  = 17'h02000,
        S_CNT   = 17'h04000,
        S_PUSH  = 17'h08000,
        S_FIN   = 17'h10000
    } t_state;

    t_state r_state, n_state;
    logic   r_inseg, n_inseg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inseg <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inseg <= n_inseg;
        end
    end

    always_comb begin
        n_state = r_state;
        n_inseg = r_inseg;
        o_cmd   = '0;
        o_cmd.div_sel = brs_pkg::DS_HAVE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.rnp_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIVH;
                end
            end
            S_DIVH: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_store = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = brs_pkg::DS_GOAL;
                    n_state = S_DIVG;
                end
            end
            S_DIVG: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_store = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = brs_pkg::DS_RGOAL;
                    n_state = S_DIVRG;
                end
            end
            S_DIVRG: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_store = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = brs_pkg::DS_RHAVE;
                    n_state = S_DIVRH;
                end
            end
            S_DIVRH: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_store = 1'b1;
                    n_state = S_BLKH;
                end
            end
            S_BLKH: begin
                o_cmd.blk_h = 1'b1;
                n_state = S_BLKG;
            end
            S_BLKG: begin
                o_cmd.blk_g = 1'b1;
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_PREP2;
            end
            S_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_inseg = 1'b0;
                n_state = S_SPAN;
            end
            S_SPAN: begin
                o_cmd.span = 1'b1;
                n_state = S_SEG;
            end
            S_SEG: begin
                if (i_sts.in_loop) begin
                    if (r_inseg) begin
                        n_state = S_EDGE;
                    end else begin
                        // locate the first peer of this segment
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = brs_pkg::DS_PEER;
                        n_state = S_DIVP;
                    end
                end else begin
                    o_cmd.seg_adv = 1'b1;
                    n_inseg = 1'b0;
                    n_state = i_sts.seg_last ? S_FIN : S_SPAN;
                end
            end
            S_DIVP: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_store = 1'b1;
                    n_inseg = 1'b1;
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                o_cmd.edge_calc = 1'b1;
                n_state = S_CNT;
            end
            S_CNT: begin
                o_cmd.cnt_calc = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                // hold while the previous transfer cannot leave as a beat
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_SEG;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// ===== src/block_redistribution_scheduler.sv =====
// Sequence: four divisions (local have, local goal, remote goal, remote have) and setup,
//   then per segment with transfers a division for its first peer and one transfer beat
//   per peer, then a final beat; an empty remote group skips straight to the final beat.
// Throughput: one request at a time; output stalls hold the walk; the next request is
//   taken once the last beat is registered.
// Reset: synchronous active-low i_rst_n returns to idle with no beat pending.
// ----------------------------------------------------------------------------
// block_redistribution_scheduler: top level
// Splits item totals by blocks and emits one beat per remote peer transfer, or one empty last beat if none.
// ----------------------------------------------------------------------------
module block_redistribution_scheduler (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  brs_pkg::t_in    i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output brs_pkg::t_out   o_data
);

    brs_pkg::t_cmd s_cmd;
    brs_pkg::t_sts s_sts;

    brs_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    brs_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (s_cmd),
        .o_sts   (s_sts),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.push |-> (!s_sts.pend_valid || s_sts.out_free))
        else $error("transfer pushed over an occupied output register");
    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.fin |-> s_sts.out_free)
        else $error("final beat loaded over an occupied output register");
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.div_start |=> s_sts.div_busy)
        else $error("divider did not start");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !s_sts.div_busy)
        else $error("divider busy while idle");
`endif

endmodule
